// ===== hdl/mersenne31_field_alu_defines.svh =====
// Assertion macros shared by the GF(31) ALU.
`ifndef MERSENNE31_FIELD_ALU_DEFINES_SVH
`define MERSENNE31_FIELD_ALU_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define M31_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define M31_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/m31alu_pkg.sv =====
package m31alu_pkg;

    localparam int unsigned FIELD_W   = 5;
    localparam int unsigned PROD_W    = 2 * FIELD_W;
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned NUM_CELLS = FIELD_W;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DBL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MULADD = 3'd4;

    localparam logic [FIELD_W-1:0] FIELD_ALT_ZERO = 5'd31;

    // One word as it travels down the chain of cells.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        logic [PROD_W-1:0]  prod;
        logic [FIELD_W-1:0] macc;
    } stage_t;

    // Fold a 6-bit sum of at most 62 back to five bits (end-around carry).
    function automatic logic [FIELD_W-1:0] fold6(input logic [FIELD_W:0] s);
        return s[FIELD_W-1:0] + {{(FIELD_W-1){1'b0}}, s[FIELD_W]};
    endfunction

    // Fold a full 10-bit product to five bits.
    function automatic logic [FIELD_W-1:0] fold10(input logic [PROD_W-1:0] v);
        logic [FIELD_W:0] s;
        s = {1'b0, v[FIELD_W-1:0]} + {1'b0, v[PROD_W-1:FIELD_W]};
        return fold6(s);
    endfunction

    // Rotate a field word left by sh bits (sh below FIELD_W).
    function automatic logic [FIELD_W-1:0] rotl(input logic [FIELD_W-1:0] x,
                                                input logic [2:0] sh);
        logic [PROD_W-1:0] w;
        w = {x, x} << sh;
        return w[PROD_W-1:FIELD_W];
    endfunction

endpackage

// ===== hdl/m31alu_cell.sv =====
module m31alu_cell #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  m31alu_pkg::stage_t in_data,
    output logic               out_valid,
    output m31alu_pkg::stage_t out_data
);
    import m31alu_pkg::*;

    logic                 valid_reg;
    stage_t               data_reg;
    stage_t               data_next;
    logic [PROD_W-1:0]    pp;
    logic [FIELD_W-1:0]   rot;

    // Each cell consumes one bit of b: it adds the shifted partial product
    // to the full product and the rotated one to the folded accumulator.
    always_comb begin
        pp  = in_data.b[BIT_IDX] ? (PROD_W'(in_data.a) << BIT_IDX) : '0;
        rot = in_data.b[BIT_IDX] ? rotl(in_data.a, 3'(BIT_IDX)) : '0;
        data_next      = in_data;
        data_next.prod = in_data.prod + pp;
        data_next.macc = fold6({1'b0, in_data.macc} + {1'b0, rot});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/m31alu_out.sv =====
module m31alu_out (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  m31alu_pkg::stage_t            in_data,
    output logic                          m_valid,
    output logic [m31alu_pkg::FIELD_W-1:0] m_result
);
    import m31alu_pkg::*;

    logic               valid_reg;
    logic [FIELD_W-1:0] result_reg;
    logic [FIELD_W-1:0] result_next;
    logic [FIELD_W-1:0] sum;

    // Add and subtract share one end-around adder; subtract uses ~b.
    always_comb begin
        if (in_data.cmd == CMD_SUB) begin
            sum = fold6({1'b0, in_data.a} + {1'b0, ~in_data.b});
        end else begin
            sum = fold6({1'b0, in_data.a} + {1'b0, in_data.b});
        end
    end

    always_comb begin
        unique case (in_data.cmd) inside
            CMD_ADD, CMD_SUB: result_next = (sum == FIELD_ALT_ZERO) ? '0 : sum;
            CMD_MUL:          result_next = fold10(in_data.prod);
            CMD_DBL:          result_next = rotl(in_data.a, 3'd1);
            CMD_MULADD:       result_next = in_data.macc;
            default:          result_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

// ===== hdl/mersenne31_field_alu.sv =====
// GF(31) field ALU: each input word carries an opcode and two 5-bit
// operands and yields exactly one 5-bit result word, in order. The code 31
// is accepted as a second encoding of zero; add and subtract always return
// 0..30, while multiply, double and interleaved multiply may return 31 for
// zero. Opcodes 5 to 7 return 0. The block accepts one word per clock cycle
// while the chain advances. Between acceptance and a valid result lie five
// cells, one per bit of operand b, each adding one partial product, and an
// output register that performs the final reduction. The whole chain advances
// together and only stalls while a finished result waits on m_ready.
module mersenne31_field_alu (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [m31alu_pkg::CMD_W-1:0]   s_cmd,
    input  logic [m31alu_pkg::FIELD_W-1:0] s_operand_a,
    input  logic [m31alu_pkg::FIELD_W-1:0] s_operand_b,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [m31alu_pkg::FIELD_W-1:0] m_result
);
    import m31alu_pkg::*;

    `include "mersenne31_field_alu_defines.svh"

    // Chain advance: everything moves unless the output holds an untaken word.
    logic   en;
    logic   stage_valid [NUM_CELLS+1];
    stage_t stage_data  [NUM_CELLS+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = aresetn && en;

    // The accumulators enter the chain cleared.
    assign stage_valid[0] = s_valid;
    assign stage_data[0]  = '{cmd: s_cmd, a: s_operand_a, b: s_operand_b,
                              prod: '0, macc: '0};

    // One cell per bit of b; cell i handles bit i.
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        m31alu_cell #(
            .BIT_IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // Final reduction and result register.
    m31alu_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (stage_valid[NUM_CELLS]),
        .in_data  (stage_data[NUM_CELLS]),
        .m_valid  (m_valid),
        .m_result (m_result)
    );

    // Reference product for checking the last cell's accumulated product.
    logic [PROD_W-1:0] last_prod_chk;
    logic              last_is_addsub;
    logic              last_valid;
    logic              last_adv;
    logic              addsub_adv;
    logic              prod_ok;
    logic              result_canon;

    assign last_prod_chk  = PROD_W'(stage_data[NUM_CELLS].a) * PROD_W'(stage_data[NUM_CELLS].b);
    assign last_is_addsub = (stage_data[NUM_CELLS].cmd == CMD_ADD) ||
                            (stage_data[NUM_CELLS].cmd == CMD_SUB);
    assign last_valid     = stage_valid[NUM_CELLS];
    assign last_adv       = last_valid && en;
    assign addsub_adv     = last_adv && last_is_addsub;
    assign prod_ok        = (stage_data[NUM_CELLS].prod == last_prod_chk);
    assign result_canon   = (m_result != FIELD_ALT_ZERO);

    // The chain of cells must have accumulated the complete product.
    `M31_ASSERT_IMP(a_prod_full, aclk, aresetn, last_valid, prod_ok, "partial product lost")
    // Add and subtract never emit the alternate encoding of zero.
    `M31_ASSERT_NXT(a_addsub_canon, aclk, aresetn, addsub_adv, result_canon, "add/sub gave 31")
    // A word leaving the last cell always lands in the output register.
    `M31_ASSERT_NXT(a_out_load, aclk, aresetn, last_adv, m_valid, "word dropped at output stage")

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import m31alu_pkg::*;

    // Opcodes 5 to 7 carry no operation; the block must answer them with zero.
    localparam logic [CMD_W-1:0] CMD_RSV5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSV6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSV7 = 3'd7;

    localparam int NO_WANT       = -1;    // row result comes from the predictor
    localparam int NUM_DIRECTED  = 25;
    localparam int NUM_RANDOM    = 1900;
    localparam int HOLD_CYCLES   = 80;    // long receiver hold-off
    localparam int IDLE_LIMIT    = 1000;  // watchdog: cycles with no word moving
    localparam int DRAIN_CYCLES  = 16;    // settling margin after the last result
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] a;
        logic [FIELD_W-1:0] b;
        int                 want;
    } stim_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd;
    logic [FIELD_W-1:0]   s_operand_a;
    logic [FIELD_W-1:0]   s_operand_b;
    logic                 m_valid;
    logic                 m_ready;
    logic [FIELD_W-1:0]   m_result;

    // Results still owed by the block, oldest first.
    logic [FIELD_W-1:0]   pending_results[$];
    int                   err_count = 0;

    // Shared flags between the stimulus, the receiver and the idling logic.
    // While no_idle is set neither side inserts gaps. Bumping hold_asked asks
    // the receiver for one long hold-off; it catches hold_served up when done.
    bit                   no_idle     = 0;
    int                   hold_asked  = 0;
    int                   hold_served = 0;

    // Directed words: extremes of both operands, every opcode, the second
    // encoding of zero, and the unused opcodes. Values that can be read off
    // at a glance are typed in; the rest go through the predictor.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_ADD,    5'd0,  5'd0,  0},
        '{CMD_ADD,    5'd31, 5'd0,  0},
        '{CMD_ADD,    5'd30, 5'd1,  0},
        '{CMD_ADD,    5'd31, 5'd31, 0},
        '{CMD_ADD,    5'd17, 5'd9,  NO_WANT},
        '{CMD_SUB,    5'd0,  5'd0,  0},
        '{CMD_SUB,    5'd5,  5'd5,  NO_WANT},
        '{CMD_SUB,    5'd0,  5'd31, 0},
        '{CMD_SUB,    5'd3,  5'd20, NO_WANT},
        '{CMD_MUL,    5'd0,  5'd31, 0},
        '{CMD_MUL,    5'd31, 5'd31, 31},
        '{CMD_MUL,    5'd1,  5'd30, 30},
        '{CMD_MUL,    5'd30, 5'd30, NO_WANT},
        '{CMD_DBL,    5'd0,  5'd0,  0},
        '{CMD_DBL,    5'd16, 5'd7,  1},
        '{CMD_DBL,    5'd31, 5'd0,  31},
        '{CMD_DBL,    5'd10, 5'd31, NO_WANT},
        '{CMD_MULADD, 5'd31, 5'd0,  0},
        '{CMD_MULADD, 5'd0,  5'd31, 0},
        '{CMD_MULADD, 5'd31, 5'd31, NO_WANT},
        '{CMD_MULADD, 5'd1,  5'd1,  1},
        '{CMD_MULADD, 5'd21, 5'd13, NO_WANT},
        '{CMD_RSV5,   5'd31, 5'd31, 0},
        '{CMD_RSV6,   5'd10, 5'd5,  0},
        '{CMD_RSV7,   5'd0,  5'd0,  0}
    };

    mersenne31_field_alu u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Fold up to ten bits onto five with an end-around carry. The first sum
    // is at most 62, so a second pass always lands within five bits.
    function automatic logic [FIELD_W-1:0] gf31_fold(input logic [PROD_W-1:0] v);
        logic [FIELD_W:0] s;
        s = {1'b0, v[FIELD_W-1:0]} + {1'b0, v[PROD_W-1:FIELD_W]};
        s = {1'b0, s[FIELD_W-1:0]} + {{FIELD_W{1'b0}}, s[FIELD_W]};
        return s[FIELD_W-1:0];
    endfunction

    // Field addition; the all-ones code is normalized to zero.
    function automatic logic [FIELD_W-1:0] gf31_sum(input logic [FIELD_W-1:0] a,
                                                    input logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] s;
        s = gf31_fold({{FIELD_W{1'b0}}, a} + {{FIELD_W{1'b0}}, b});
        return (s == FIELD_ALT_ZERO) ? '0 : s;
    endfunction

    // Expected result word for one operation.
    function automatic logic [FIELD_W-1:0] gf31_expected(input logic [CMD_W-1:0] cmd,
                                                         input logic [FIELD_W-1:0] a,
                                                         input logic [FIELD_W-1:0] b);
        logic [FIELD_W-1:0] acc;
        logic [FIELD_W-1:0] part;
        case (cmd)
            CMD_ADD: begin
                return gf31_sum(a, b);
            end
            CMD_SUB: begin
                // Subtraction is addition of the one's complement, which is
                // the negation in this field.
                return gf31_sum(a, ~b);
            end
            CMD_MUL: begin
                return gf31_fold({{FIELD_W{1'b0}}, a} * {{FIELD_W{1'b0}}, b});
            end
            CMD_DBL: begin
                return gf31_fold({{(FIELD_W-1){1'b0}}, a, 1'b0});
            end
            CMD_MULADD: begin
                // Shift-and-add: each set bit of b contributes a rotated copy
                // of a, and the running sum is folded after every step.
                acc = b[0] ? a : '0;
                for (int i = 1; i < FIELD_W; i++) begin
                    part = b[i] ? gf31_fold({{FIELD_W{1'b0}}, a} << i) : '0;
                    acc  = gf31_fold({{FIELD_W{1'b0}}, acc} + {{FIELD_W{1'b0}}, part});
                end
                return acc;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        err_count++;
        if (err_count <= MAX_PRINTS) begin
            $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // Gap length for either side: mostly none, sometimes a few cycles, and
    // now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || (hold_asked != hold_served)) begin
            return 0;
        end else if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 30);
        end
    endfunction

    // Operands lean on the edges of the field, including the second zero.
    function automatic logic [FIELD_W-1:0] pick_operand();
        logic [FIELD_W-1:0] edges [6] = '{5'd0, 5'd1, 5'd15, 5'd16, 5'd30, 5'd31};
        if ($urandom_range(0, 3) == 0) begin
            return edges[$urandom_range(0, 5)];
        end
        return FIELD_W'($urandom_range(0, 31));
    endfunction

    // Offer one word starting at a falling edge and hold it until it is
    // taken. The expected result is queued at the accepting edge; the
    // registered chain keeps that ahead of the result check. Afterwards a gap
    // may follow, and the task returns at a falling edge.
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] a,
                             input logic [FIELD_W-1:0] b, input int want);
        int gap;
        s_valid     = 1'b1;
        s_cmd       = cmd;
        s_operand_a = a;
        s_operand_b = b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (want == NO_WANT) begin
            pending_results.push_back(gf31_expected(cmd, a, b));
        end else begin
            pending_results.push_back(want[FIELD_W-1:0]);
        end
        @(negedge aclk);
        gap = idle_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Every accepted result word is checked against the oldest pending one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result word", m_result, '0);
            end else if (m_result !== pending_results[0]) begin
                report_mismatch("result mismatch", m_result, pending_results.pop_front());
            end else begin
                void'(pending_results.pop_front());
            end
        end
    end

    // Receiver: random stalls on m_ready, plus a long hold-off on request so
    // that the pipeline fills and the block has to drop s_ready.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_asked != hold_served) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready     = 1'b1;
                hold_served = hold_asked;
            end else begin
                gap = idle_gap();
                if (gap == 0) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    repeat (gap - 1) @(negedge aclk);
                end
            end
        end
    end

    // Watchdog: a stuck handshake on either side ends the run as a failure.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: reset, directed table, then random words with a gap-free
    // stretch and two back-pressure bursts, then drain and report.
    initial begin
        logic [CMD_W-1:0] cmd;
        int               r;
        s_valid     = 1'b0;
        s_cmd       = '0;
        s_operand_a = '0;
        s_operand_b = '0;
        aresetn     = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_word(directed_rows[i].cmd, directed_rows[i].a, directed_rows[i].b,
                      directed_rows[i].want);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            // The receiver freezes while the sender keeps pushing words.
            if (n == 300 || n == 1300) begin
                hold_asked++;
            end
            no_idle = (n >= 600 && n < 800);
            // Mostly real opcodes, a few of the unused ones.
            r = $urandom_range(0, 15);
            if (r < 14) begin
                cmd = CMD_W'(r % 5);
            end else begin
                cmd = CMD_W'($urandom_range(CMD_RSV5, CMD_RSV7));
            end
            send_word(cmd, pick_operand(), pick_operand(), NO_WANT);
        end
        s_valid = 1'b0;
        no_idle = 1'b0;

        // The watchdog covers a result that never arrives.
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
